FILE: rtl/btb_pkg.sv
package btb_pkg;

  localparam int BtbDepth = 32;
  localparam int HistMax = 8;
  localparam int HistEntries = 1 << HistMax;
  localparam int EntryW = $clog2(BtbDepth);
  localparam int LocalDepth = BtbDepth * HistEntries;
  localparam int LocalAw = $clog2(LocalDepth);
  localparam int TagW = 30;
  localparam int MaxLog2 = EntryW;

  localparam logic [2:0] RegBtbSize = 3'd0;
  localparam logic [2:0] RegHistBits = 3'd1;
  localparam logic [2:0] RegTagBits = 3'd2;
  localparam logic [2:0] RegInitState = 3'd3;
  localparam logic [2:0] RegGlobalHist = 3'd4;
  localparam logic [2:0] RegGlobalTable = 3'd5;
  localparam logic [2:0] RegShareMode = 3'd6;

  localparam logic [1:0] ShareNone = 2'd0;
  localparam logic [1:0] SharePc2 = 2'd1;
  localparam logic [1:0] SharePc16 = 2'd2;

  typedef struct packed {
    logic mode;
    logic [31:0] pc;
    logic [31:0] actual_target;
    logic taken;
    logic [31:0] predicted_dest;
  } in_word_t;

  typedef struct packed {
    logic predict_taken;
    logic [31:0] next_address;
    logic flush;
    logic [31:0] branch_total;
    logic [31:0] flush_total;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;   // clear one entry of the shared counter table
    logic clear_start;  // reset counts, valid bits, history
    logic load;         // capture the input word, issue lookup
    logic finish;       // evaluate and commit, load result
    logic row_step;     // rewrite one counter of the replaced entry's row
  } btb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic row_needed;   // train missed with per-entry tables: row rewrite
    logic row_done;
  } btb_stat_t;

endpackage

FILE: rtl/btb_if.sv
interface btb_in_if;
  import btb_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface btb_out_if;
  import btb_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface btb_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] value;
  modport source(output valid, output index, output value, input ready);
  modport sink(input valid, input index, input value, output ready);
endinterface

FILE: rtl/btb_ctrl.sv
module btb_ctrl
  import btb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output btb_cmd_t cmd,
  input  btb_stat_t stat
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EVAL, S_ROWCLR, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && !cfg_write;
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.clear_step = (state == S_CLEAR);
    cmd.clear_start = cfg_write;
    cmd.load = in_valid && in_ready;
    cmd.finish = (state == S_EVAL);
    cmd.row_step = (state == S_ROWCLR);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_EVAL;
        S_EVAL: begin
          if (stat.row_needed) state <= S_ROWCLR;
          else state <= S_OUT;
        end
        S_ROWCLR: if (stat.row_done) state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready) else $error("accept during clear");
  a_eval_to_out: assert property (@(posedge clk) disable iff (rst || cfg_write)
    state == S_EVAL |=> state == S_OUT || state == S_ROWCLR) else $error("eval stuck");
  a_out_hold: assert property (@(posedge clk) disable iff (rst || cfg_write)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif

endmodule

FILE: rtl/btb_dp.sv
module btb_dp
  import btb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_value,
  input  btb_cmd_t cmd,
  output btb_stat_t stat,
  input  in_word_t in_word,
  output out_word_t out_word
);

  logic [2:0] size_log2;
  logic [3:0] hist_bits;
  logic [4:0] tag_bits;
  logic [1:0] init_state;
  logic g_hist, g_table;
  logic [1:0] share;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= 3'd5; hist_bits <= 4'd8; tag_bits <= 5'd30;
      init_state <= 2'd1; g_hist <= 1'b0; g_table <= 1'b0; share <= ShareNone;
    end else if (cfg_write) begin
      case (cfg_index)
        RegBtbSize: size_log2 <= cfg_value[2:0];
        RegHistBits: hist_bits <= cfg_value[3:0];
        RegTagBits: tag_bits <= cfg_value[4:0];
        RegInitState: init_state <= cfg_value[1:0];
        RegGlobalHist: g_hist <= cfg_value[0];
        RegGlobalTable: g_table <= cfg_value[0];
        RegShareMode: share <= cfg_value[1:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [2:0] eff_log2;
  logic [3:0] eff_hist;
  logic [4:0] eff_tag;
  logic [HistMax-1:0] hmask;
  logic [EntryW-1:0] emask;
  logic [TagW-1:0] tmask;
  assign eff_log2 = (size_log2 > 3'(MaxLog2)) ? 3'(MaxLog2) : size_log2;
  assign eff_hist = (hist_bits > 4'(HistMax)) ? 4'(HistMax) : hist_bits;
  assign eff_tag = (tag_bits > 5'(TagW)) ? 5'(TagW) : tag_bits;
  assign hmask = HistMax'((9'd1 << eff_hist) - 9'd1);
  assign emask = EntryW'((6'd1 << eff_log2) - 6'd1);
  assign tmask = TagW'((31'd1 << eff_tag) - 31'd1);

  // entry state
  logic [BtbDepth-1:0] valid_bits;
  logic [TagW-1:0] tag_mem [BtbDepth];
  logic [31:0] tgt_mem [BtbDepth];
  logic [HistMax-1:0] hist_reg [BtbDepth];
  logic [HistMax-1:0] shared_hist;
  logic [31:0] branch_cnt, flush_cnt;

  // counter memories: shared table swept after clear, local rows on replacement
  logic [1:0] local_mem [LocalDepth];
  logic [1:0] shared_mem [HistEntries];
  logic [HistMax:0] clr_ptr;
  logic [HistMax:0] row_ptr;
  logic [HistMax-1:0] row_slot;
  logic [1:0] row_val;

  in_word_t cur;
  logic [EntryW-1:0] e_l;
  logic [HistMax-1:0] h_l;
  logic [HistMax-1:0] idx_l;
  logic [HistMax-1:0] x_l;
  logic [TagW-1:0] tag_l;
  logic [1:0] lc_rd, sc_rd, sx_rd;

  logic [EntryW-1:0] e_c;
  logic [TagW-1:0] tag_c;
  logic [HistMax-1:0] h_c, x_c, idx_c;
  logic [31:0] pc4_c;
  assign e_c = in_word.pc[2 +: EntryW] & emask;
  assign tag_c = TagW'(in_word.pc[31:2] >> eff_log2) & tmask;
  assign h_c = (g_hist ? shared_hist : hist_reg[e_c]) & hmask;
  always_comb begin
    case (share)
      SharePc2: x_c = in_word.pc[2 +: HistMax] & hmask;
      SharePc16: x_c = in_word.pc[16 +: HistMax] & hmask;
      default: x_c = '0;
    endcase
  end
  assign idx_c = g_table ? (h_c ^ x_c) : h_c;
  assign pc4_c = cur.pc + 32'd4;

  logic hit, miss_clr_hist;
  logic [HistMax-1:0] idx_t;
  logic [1:0] ctr, ctr_new;
  logic fl;
  assign hit = valid_bits[e_l] && (tag_mem[e_l] == tag_l);
  // a miss with per-entry history trains at history zero
  assign miss_clr_hist = !hit && !g_hist;
  assign idx_t = miss_clr_hist ? (g_table ? x_l : '0) : idx_l;
  // a missed per-entry row restarts at the initial state
  assign ctr = g_table ? (miss_clr_hist ? sx_rd : sc_rd) : (hit ? lc_rd : init_state);
  assign ctr_new = cur.taken ? ((ctr == 2'd3) ? ctr : ctr + 2'd1)
                             : ((ctr == 2'd0) ? ctr : ctr - 2'd1);
  assign fl = cur.taken ? (cur.predicted_dest != cur.actual_target)
                        : (cur.predicted_dest != pc4_c);

  assign stat.clear_done = clr_ptr[HistMax];
  assign stat.row_needed = cur.mode && !g_table && !hit;
  assign stat.row_done = row_ptr[HistMax];

  always_ff @(posedge clk) begin
    if (cmd.clear_start || rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear_step && !clr_ptr[HistMax]) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ptr <= '0;
    end else if (cmd.finish) begin
      row_ptr <= '0;
    end else if (cmd.row_step && !row_ptr[HistMax]) begin
      row_ptr <= row_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      row_slot <= idx_t;
      row_val <= ctr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && !clr_ptr[HistMax]) begin
      shared_mem[clr_ptr[HistMax-1:0]] <= init_state;
    end else if (cmd.finish && cur.mode && g_table) begin
      shared_mem[idx_t] <= ctr_new;
    end
    if (cmd.load) begin
      sc_rd <= shared_mem[idx_c];
      sx_rd <= shared_mem[x_c];
    end
  end

  // replaced row: every slot back to initial state, trained slot gets its new value
  always_ff @(posedge clk) begin
    if (cmd.row_step && !row_ptr[HistMax]) begin
      local_mem[{e_l, row_ptr[HistMax-1:0]}] <=
        (row_ptr[HistMax-1:0] == row_slot) ? row_val : init_state;
    end else if (cmd.finish && cur.mode && !g_table && hit) begin
      local_mem[{e_l, idx_l}] <= ctr_new;
    end
    if (cmd.load) lc_rd <= local_mem[{e_c, idx_c}];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      valid_bits <= '0;
      shared_hist <= '0;
      branch_cnt <= '0;
      flush_cnt <= '0;
      for (int i = 0; i < BtbDepth; i++) hist_reg[i] <= '0;
    end else if (cmd.finish && cur.mode) begin
      valid_bits[e_l] <= 1'b1;
      branch_cnt <= branch_cnt + 32'd1;
      if (fl) flush_cnt <= flush_cnt + 32'd1;
      if (g_hist) shared_hist <= ((shared_hist << 1) | HistMax'(cur.taken)) & hmask;
      else hist_reg[e_l] <= (((hit ? h_l : '0) << 1) | HistMax'(cur.taken)) & hmask;
    end
  end

  logic [31:0] tgt_l;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= in_word;
      e_l <= e_c;
      tag_l <= tag_c;
      h_l <= hist_reg[e_c] & hmask;
      idx_l <= idx_c;
      x_l <= x_c;
      tgt_l <= tgt_mem[e_c];
    end
    if (cmd.finish && cur.mode) begin
      tgt_mem[e_l] <= cur.actual_target;
      if (!hit) tag_mem[e_l] <= tag_l;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cur.mode) begin
        out_word.predict_taken <= 1'b0;
        out_word.next_address <= '0;
        out_word.flush <= fl;
        out_word.branch_total <= branch_cnt + 32'd1;
        out_word.flush_total <= flush_cnt + 32'(fl);
      end else begin
        out_word.predict_taken <= hit && ctr[1];
        out_word.next_address <= (hit && ctr[1]) ? tgt_l : pc4_c;
        out_word.flush <= 1'b0;
        out_word.branch_total <= branch_cnt;
        out_word.flush_total <= flush_cnt;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_order: assert property (@(posedge clk) disable iff (rst || cmd.clear_start)
    cmd.finish && cur.mode |=> branch_cnt == $past(branch_cnt) + 32'd1)
    else $error("branch count");
  a_flush_le: assert property (@(posedge clk) disable iff (rst)
    out_word.flush |-> out_word.predict_taken == 1'b0) else $error("flush on predict");
  a_valid_set: assert property (@(posedge clk) disable iff (rst || cmd.clear_start)
    cmd.finish && cur.mode |=> valid_bits[$past(e_l)]) else $error("valid not set");
`endif

endmodule

FILE: rtl/btb_two_level_branch_predictor_top.sv
// channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | mode, pc, actual_target, taken, predicted_dest
// out_ch  | out | valid/ready | predict_taken, next_address, flush, totals
// cfg_ch  | in  | valid/ready | index (3), value (32)
//
// Each word goes through a lookup read, then evaluate/commit, and its
// result then waits in the output register until taken; one word in flight.
// A train that misses while per-entry counter tables are in use rewrites
// that entry's 256-counter row, one counter a cycle, before the result is
// offered. Rows are rewritten on every such miss, so the per-entry memory
// needs no sweep after reset.
// After reset or any config write to registers 0 to 6 the shared counter
// table is swept, one entry a cycle, with no word accepted until it ends.
// rst is synchronous, active high; config is always accepted.
module btb_two_level_branch_predictor_top
  import btb_pkg::*;
(
  input logic clk,
  input logic rst,
  btb_in_if.sink in_ch,
  btb_out_if.source out_ch,
  btb_cfg_if.sink cfg_ch
);

  btb_cmd_t cmd;
  btb_stat_t stat;
  logic cfg_write;

  assign cfg_ch.ready = 1'b1;
  assign cfg_write = cfg_ch.valid && (cfg_ch.index <= RegShareMode);

  btb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_write(cfg_write),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  btb_dp u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_write),
    .cfg_index(cfg_ch.index), .cfg_value(cfg_ch.value),
    .cmd(cmd), .stat(stat),
    .in_word(in_ch.data), .out_word(out_ch.data)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import btb_pkg::*;

  logic clk;
  logic rst;

  btb_in_if in_ch();
  btb_out_if out_ch();
  btb_cfg_if cfg_ch();

  btb_two_level_branch_predictor_top dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the predictor: registers and state, at the block's widths
  // ---------------------------------------------------------------------------
  logic [2:0] sh_size_log2;
  logic [3:0] sh_hist_bits;
  logic [4:0] sh_tag_bits;
  logic [1:0] sh_init;
  logic       sh_ghist;
  logic       sh_gtable;
  logic [1:0] sh_share;

  logic        ent_valid [BtbDepth];
  logic [31:0] ent_tag [BtbDepth];
  logic [31:0] ent_target [BtbDepth];
  logic [7:0]  ent_hist [BtbDepth];
  logic [1:0]  loc_ctr [LocalDepth];
  logic [1:0]  shr_ctr [HistEntries];
  logic [7:0]  shr_hist;
  logic [31:0] branch_cnt;
  logic [31:0] flush_cnt;

  out_word_t exp_q[$];   // predicted result words, oldest first
  int        err_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;

  // A write to register 0 to 6 wipes all state but the settings back to the reset picture.
  task automatic wipe_state();
    for (int i = 0; i < BtbDepth; i++) begin
      ent_valid[i] = 1'b0;
      ent_tag[i] = '0;
      ent_target[i] = '0;
      ent_hist[i] = '0;
    end
    for (int i = 0; i < LocalDepth; i++) loc_ctr[i] = sh_init;
    for (int i = 0; i < HistEntries; i++) shr_ctr[i] = sh_init;
    shr_hist = '0;
    branch_cnt = '0;
    flush_cnt = '0;
  endtask

  function automatic logic [7:0] hmask();
    int h;
    h = (sh_hist_bits > HistMax) ? HistMax : sh_hist_bits;
    return 8'((1 << h) - 1);
  endfunction

  // Counter slot: index into the shared table or the flat per-entry table.
  function automatic int ctr_slot(logic [31:0] pc, int e);
    logic [7:0] h;
    logic [7:0] x;
    h = (sh_ghist ? shr_hist : ent_hist[e]) & hmask();
    if (sh_gtable) begin
      x = '0;
      if (sh_share == SharePc2) x = 8'(pc >> 2) & hmask();
      else if (sh_share == SharePc16) x = 8'(pc >> 16) & hmask();
      return int'(h ^ x);
    end
    return e * HistEntries + int'(h);
  endfunction

  // Resolve one word against the shadow state; returns the expected result.
  function automatic out_word_t btb_resolve(in_word_t w);
    out_word_t  r;
    int         l;
    int         tb;
    int         e;
    int         s;
    logic [31:0] tag;
    logic [1:0] c;
    logic       hit;
    logic [31:0] fall;
    l = (sh_size_log2 > MaxLog2) ? MaxLog2 : sh_size_log2;
    tb = (sh_tag_bits > TagW) ? TagW : sh_tag_bits;
    e = int'((w.pc >> 2) & ((32'd1 << l) - 1));
    tag = ((w.pc >> 2) >> l) & ((32'd1 << tb) - 1);
    hit = ent_valid[e] && ent_tag[e] == tag;
    fall = w.pc + 32'd4;
    r = '0;
    if (!w.mode) begin
      s = ctr_slot(w.pc, e);
      c = sh_gtable ? shr_ctr[s] : loc_ctr[s];
      r.predict_taken = hit && c >= 2'd2;
      r.next_address = r.predict_taken ? ent_target[e] : fall;
      r.branch_total = branch_cnt;
      r.flush_total = flush_cnt;
      return r;
    end
    // miss: replace the entry, restart its per-entry history and counter row where in use
    if (!hit) begin
      ent_tag[e] = tag;
      if (!sh_gtable && ent_valid[e])
        for (int i = 0; i < HistEntries; i++) loc_ctr[e * HistEntries + i] = sh_init;
      if (!sh_ghist) ent_hist[e] = '0;
    end
    ent_target[e] = w.actual_target;
    s = ctr_slot(w.pc, e);
    c = sh_gtable ? shr_ctr[s] : loc_ctr[s];
    if (w.taken && c != 2'd3) c = c + 2'd1;
    else if (!w.taken && c != 2'd0) c = c - 2'd1;
    if (sh_gtable) shr_ctr[s] = c;
    else loc_ctr[s] = c;
    if (sh_ghist) shr_hist = {shr_hist[6:0], w.taken} & hmask();
    else ent_hist[e] = {ent_hist[e][6:0], w.taken} & hmask();
    ent_valid[e] = 1'b1;
    branch_cnt = branch_cnt + 32'd1;
    if ((w.taken && w.predicted_dest != w.actual_target) ||
        (!w.taken && w.predicted_dest != fall)) begin
      flush_cnt = flush_cnt + 32'd1;
      r.flush = 1'b1;
    end
    r.branch_total = branch_cnt;
    r.flush_total = flush_cnt;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted result word with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t g;
    out_word_t x;
    if (!rst && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (exp_q.size() == 0) begin
        $display("%0t: result word with nothing expected", $realtime);
        err_cnt++;
      end else begin
        x = exp_q.pop_front();
        if (g.predict_taken !== x.predict_taken)
          report("predict_taken", 32'(g.predict_taken), 32'(x.predict_taken));
        if (g.next_address !== x.next_address)
          report("next_address", g.next_address, x.next_address);
        if (g.flush !== x.flush) report("flush", 32'(g.flush), 32'(x.flush));
        if (g.branch_total !== x.branch_total)
          report("branch_total", g.branch_total, x.branch_total);
        if (g.flush_total !== x.flush_total)
          report("flush_total", g.flush_total, x.flush_total);
      end
    end
  end

  // Receiver: ready drops at random per the current stall rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Send one word; the expectation is taken at acceptance, or the typed one.
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_res,
                           output out_word_t res);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    res = btb_resolve(w);
    exp_q.push_back(typed ? typed_res : res);
  endtask

  // Register write; only called with nothing in flight. The caller drops valid.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      RegBtbSize:     sh_size_log2 = val[2:0];
      RegHistBits:    sh_hist_bits = val[3:0];
      RegTagBits:     sh_tag_bits = val[4:0];
      RegInitState:   sh_init = val[1:0];
      RegGlobalHist:  sh_ghist = val[0];
      RegGlobalTable: sh_gtable = val[0];
      RegShareMode:   sh_share = val[1:0];
      default:        ;
    endcase
    if (idx <= RegShareMode) wipe_state();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: default registers straight after reset
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  localparam logic Predict = 1'b0;
  localparam logic Train = 1'b1;

  dir_row_t dir_tab[] = '{
    // empty buffer: fall-through, zero totals
    '{'{Predict, 32'h0, 32'h0, 1'b0, 32'h0}, 1'b1, '{1'b0, 32'h4, 1'b0, 32'd0, 32'd0}},
    // pc+4 wraps
    '{'{Predict, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 32'h3, 1'b0, 32'd0, 32'd0}},
    // first train, correct destination: counted, no flush
    '{'{Train, 32'h100, 32'h2000, 1'b1, 32'h2000}, 1'b1,
      '{1'b0, 32'h0, 1'b0, 32'd1, 32'd0}},
    '{'{Predict, 32'h100, 32'h0, 1'b0, 32'h0}, 1'b0, '{default: '0}},
    // taken but predicted fall-through: flush
    '{'{Train, 32'h100, 32'h2000, 1'b1, 32'h104}, 1'b0, '{default: '0}},
    '{'{Train, 32'h100, 32'h2000, 1'b1, 32'h2000}, 1'b0, '{default: '0}},
    '{'{Predict, 32'h100, 32'h0, 1'b0, 32'h0}, 1'b0, '{default: '0}},
    // not taken, predicted the stored target: flush
    '{'{Train, 32'h100, 32'h2000, 1'b0, 32'h2000}, 1'b0, '{default: '0}},
    '{'{Train, 32'h100, 32'h2000, 1'b0, 32'h104}, 1'b0, '{default: '0}},
    // top of the address space
    '{'{Train, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'h0}, 1'b0, '{default: '0}},
    '{'{Train, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1'b0, '{default: '0}},
    '{'{Predict, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0}, 1'b0, '{default: '0}},
    // same entry, other tag: replacement of a valid entry
    '{'{Train, 32'h180, 32'h4000, 1'b1, 32'h184}, 1'b0, '{default: '0}},
    '{'{Predict, 32'h100, 32'h0, 1'b0, 32'h0}, 1'b0, '{default: '0}},
    '{'{Predict, 32'h180, 32'h0, 1'b0, 32'h0}, 1'b0, '{default: '0}},
    '{'{Train, 32'h100, 32'h0, 1'b0, 32'h104}, 1'b0, '{default: '0}},
    '{'{Predict, 32'h180, 32'h0, 1'b1, 32'h0}, 1'b0, '{default: '0}}
  };

  // Register settings: extremes, saturation cases and a few mixes.
  typedef logic [31:0] reg_set_t [7];
  reg_set_t settings[] = '{
    '{32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd5, 32'd8, 32'd30, 32'd3, 32'd1, 32'd1, 32'd2},
    '{32'd7, 32'd15, 32'd31, 32'd2, 32'd0, 32'd1, 32'd3},
    '{32'd2, 32'd3, 32'd5, 32'd1, 32'd1, 32'd0, 32'd1},
    '{32'd1, 32'd0, 32'd2, 32'd2, 32'd0, 32'd1, 32'd2},
    '{32'd3, 32'd4, 32'd12, 32'd0, 32'd1, 32'd1, 32'd1},
    '{32'd4, 32'd8, 32'd1, 32'd3, 32'd0, 32'd0, 32'd0},
    '{32'd5, 32'd8, 32'd30, 32'd1, 32'd0, 32'd0, 32'd0}
  };

  localparam int RandWords = 1000;
  localparam int WidthOf[7] = '{3, 4, 5, 2, 1, 1, 2};

  initial begin
    in_word_t    w;
    out_word_t   r;
    logic [31:0] pool[8];
    logic [31:0] v;
    int          per_set;
    int          sent;
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.value = '0;
    err_cnt = 0;
    send_idle_pct = 20;
    recv_stall_pct = 82;
    sh_size_log2 = 3'd5;
    sh_hist_bits = 4'd8;
    sh_tag_bits = 5'd30;
    sh_init = 2'd1;
    sh_ghist = 1'b0;
    sh_gtable = 1'b0;
    sh_share = ShareNone;
    wipe_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res, r);
    drain();
    // an index past the register list leaves everything alone
    write_reg(3'd7, $urandom);
    cfg_ch.valid <= 1'b0;

    per_set = RandWords / settings.size();
    sent = 0;
    foreach (settings[k]) begin
      drain();
      // upper value bits are random: only the low register bits count
      for (int i = 0; i <= int'(RegShareMode); i++) begin
        v = settings[k][i] | ($urandom << WidthOf[i]);
        write_reg(3'(i), v);
      end
      cfg_ch.valid <= 1'b0;
      // a small set of branch addresses so entries get hit and evicted
      foreach (pool[i]) pool[i] = (($urandom_range(0, 3) == 0) ? ($urandom << 2) : 32'h0)
                                  ^ (32'($urandom_range(0, 63)) << 2);
      while (sent < per_set * (k + 1)) begin
        // idling schedule: slow receiver, then slow sender, then full speed
        if (sent < RandWords / 3) begin
          send_idle_pct = 20; recv_stall_pct = 82;
        end else if (sent < 2 * RandWords / 3) begin
          send_idle_pct = 82; recv_stall_pct = 20;
        end else begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        w.mode = 1'($urandom);
        w.pc = $urandom;
        w.actual_target = $urandom;
        w.taken = 1'($urandom);
        w.predicted_dest = $urandom;
        if ($urandom_range(0, 9) < 8) begin
          // predict, then train the same branch, mostly with what was predicted
          w.pc = pool[$urandom_range(0, 7)] | 32'($urandom_range(0, 1) * 2);
          w.mode = Predict;
          send_word(w, 1'b0, r, r);
          w.mode = Train;
          if ($urandom_range(0, 3) != 0) w.actual_target = pool[$urandom_range(0, 7)];
          w.predicted_dest = ($urandom_range(0, 7) != 0) ? r.next_address : $urandom;
          send_word(w, 1'b0, r, r);
          sent += 2;
        end else begin
          send_word(w, 1'b0, r, r);
          sent++;
        end
      end
    end
    drain();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("%0t: timeout", $realtime);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
rtl/btb_pkg.sv
rtl/btb_if.sv
rtl/btb_ctrl.sv
rtl/btb_dp.sv
rtl/btb_two_level_branch_predictor_top.sv
test/tb.sv
